[design/bkre_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkre_pkg
// Shared constants, types and tables for the boot keyboard report decoder.
// ----------------------------------------------------------------------------
package bkre_pkg;

	// Report layout and event numbering.
	localparam int KEY_SLOTS  = 6;
	localparam int NUM_MODS   = 6;
	localparam int NUM_EVENTS = NUM_MODS + 2 * KEY_SLOTS;

	localparam logic [6:0] MIN_REPORT_LEN = 7'd8;
	localparam logic [7:0] KEY_NONE_MAX   = 8'd3;

	// Tracked modifier bits; the GUI bits never enter the latch.
	localparam logic [7:0] MOD_TRACK_MASK = 8'h77;

	// Modifier bit and usage code per tracked modifier, left ctrl first.
	localparam logic [NUM_MODS-1:0][7:0] MOD_BITS =
		{8'h40, 8'h20, 8'h10, 8'h04, 8'h02, 8'h01};
	localparam logic [NUM_MODS-1:0][7:0] MOD_CODES =
		{8'hE6, 8'hE5, 8'hE4, 8'hE2, 8'hE1, 8'hE0};

	typedef logic [NUM_EVENTS-1:0] ev_mask_t;
	typedef logic [KEY_SLOTS-1:0][7:0] keys_t;

	// One report after comparison with the stored state: which events fire
	// and what they need to be built.
	typedef struct packed {
		ev_mask_t              mask;
		logic [NUM_MODS-1:0]   mod_now;
		keys_t                 old_keys;
		keys_t                 cur_keys;
		logic [7:0]            mods;
	} ev_set_t;

endpackage

[design/bkre_report_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkre_report_if
// Channel that carries one boot keyboard report word.
// ----------------------------------------------------------------------------
interface bkre_report_if;

	logic       valid;
	logic       ready;
	logic [7:0] modifiers;
	logic [7:0] key_0;
	logic [7:0] key_1;
	logic [7:0] key_2;
	logic [7:0] key_3;
	logic [7:0] key_4;
	logic [7:0] key_5;
	logic [6:0] report_length;

	modport source (
		output valid, modifiers, key_0, key_1, key_2, key_3, key_4, key_5,
		       report_length,
		input  ready
	);

	modport sink (
		input  valid, modifiers, key_0, key_1, key_2, key_3, key_4, key_5,
		       report_length,
		output ready
	);

endinterface

[design/bkre_event_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkre_event_if
// Channel that carries one key event word.
// ----------------------------------------------------------------------------
interface bkre_event_if;

	logic       valid;
	logic       ready;
	logic [7:0] usage_code;
	logic       pressed;
	logic [7:0] modifier_info;
	logic       last;

	modport source (
		output valid, usage_code, pressed, modifier_info, last,
		input  ready
	);

	modport sink (
		input  valid, usage_code, pressed, modifier_info, last,
		output ready
	);

endinterface

[design/bkre_diff.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkre_diff
// Holds the previous key slots and the modifier latch, and compares a report
// against them to find every modifier and key event it causes.
// ----------------------------------------------------------------------------
module bkre_diff (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             update,
	input  logic [7:0]       mods,
	input  bkre_pkg::keys_t  keys,
	output bkre_pkg::ev_set_t ev_set
);
	import bkre_pkg::*;

	keys_t      prev_keys_q;
	logic [7:0] mod_latch_q;

	// Event flags: modifier changes first, then release and press per slot.
	always_comb begin
		logic in_new;
		logic in_old;
		ev_set.mask     = '0;
		ev_set.mod_now  = '0;
		ev_set.old_keys = prev_keys_q;
		ev_set.cur_keys = keys;
		ev_set.mods     = mods;
		for (int m = 0; m < NUM_MODS; m++) begin
			ev_set.mod_now[m] = |(mods & MOD_BITS[m]);
			ev_set.mask[m]    = ev_set.mod_now[m] != (|(mod_latch_q & MOD_BITS[m]));
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			in_new = 1'b0;
			in_old = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				in_new = in_new | (keys[j] == prev_keys_q[i]);
				in_old = in_old | (prev_keys_q[j] == keys[i]);
			end
			ev_set.mask[NUM_MODS + 2 * i]     = (prev_keys_q[i] > KEY_NONE_MAX) && !in_new;
			ev_set.mask[NUM_MODS + 2 * i + 1] = (keys[i] > KEY_NONE_MAX) && !in_old;
		end
	end

	// State moves to the new report when its events are committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
			mod_latch_q <= '0;
		end else if (update) begin
			prev_keys_q <= keys;
			mod_latch_q <= mods & MOD_TRACK_MASK;
		end
	end

endmodule

[design/bkre_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkre_emit
// Holds the pending events of one report and sends them out in order, one
// word per cycle while the sink is ready, through an output register.
// ----------------------------------------------------------------------------
module bkre_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  bkre_pkg::ev_set_t ev_set,
	output logic              free,
	bkre_event_if.source      evt
);
	import bkre_pkg::*;

	ev_mask_t   mask_s2;
	ev_set_t    set_s2;
	ev_mask_t   onehot;
	ev_mask_t   remain;
	logic       pop;
	logic       out_valid_q;
	logic [7:0] sel_code;
	logic       sel_pressed;
	logic [7:0] sel_info;
	logic [7:0] code_q;
	logic       pressed_q;
	logic [7:0] info_q;
	logic       last_q;

	// Lowest pending event goes next.
	assign onehot = mask_s2 & (~mask_s2 + ev_mask_t'(1));
	assign remain = mask_s2 & ~onehot;
	assign pop    = (|mask_s2) && (!out_valid_q || evt.ready);
	assign free   = (mask_s2 == '0) || (pop && (remain == '0));

	// Build the selected event from the one-hot pick.
	always_comb begin
		sel_code    = '0;
		sel_pressed = 1'b0;
		sel_info    = '0;
		for (int m = 0; m < NUM_MODS; m++) begin
			if (onehot[m]) begin
				sel_code    = sel_code | MOD_CODES[m];
				sel_pressed = sel_pressed | set_s2.mod_now[m];
				sel_info    = sel_info | MOD_BITS[m];
			end
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (onehot[NUM_MODS + 2 * i]) begin
				sel_code = sel_code | set_s2.old_keys[i];
				sel_info = sel_info | set_s2.mods;
			end
			if (onehot[NUM_MODS + 2 * i + 1]) begin
				sel_code    = sel_code | set_s2.cur_keys[i];
				sel_pressed = 1'b1;
				sel_info    = sel_info | set_s2.mods;
			end
		end
	end

	// Pending event flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (load) begin
			mask_s2 <= ev_set.mask;
		end else if (pop) begin
			mask_s2 <= remain;
		end
	end

	// Event payload of the report being sent.
	always_ff @(posedge clk) begin
		if (load) begin
			set_s2 <= ev_set;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			code_q    <= sel_code;
			pressed_q <= sel_pressed;
			info_q    <= sel_info;
			last_q    <= (remain == '0);
		end
	end

	assign evt.valid         = out_valid_q;
	assign evt.usage_code    = code_q;
	assign evt.pressed       = pressed_q;
	assign evt.modifier_info = info_q;
	assign evt.last          = last_q;

endmodule

[design/boot_keyboard_report_to_key_events.sv]
`timescale 1ns / 1ps
// Path: an accepted report word passes the input register and the pending
// event flags; its first event then leaves through the output register.
// Throughput: one event word per cycle while the sink is ready; a report
// holds the event stage until its last event moves to the output register.
// Reset: arst_n clears the pipeline valids, the key slots and the modifier latch.
// ----------------------------------------------------------------------------
// boot_keyboard_report_to_key_events
// Turns boot keyboard reports into press and release events by comparing
// each full-length report with the previous full-length one; short ones are ignored.
// ----------------------------------------------------------------------------
module boot_keyboard_report_to_key_events (
	input  logic          clk,
	input  logic          arst_n,
	bkre_report_if.sink   rpt,
	bkre_event_if.source  evt
);
	import bkre_pkg::*;

	logic       valid_s1;
	logic [7:0] mods_s1;
	keys_t      keys_s1;
	logic [6:0] len_s1;
	logic       emit_free;
	logic       advance;
	logic       load;
	ev_set_t    ev_set;

	assign rpt.ready = !valid_s1 || emit_free;
	assign advance   = valid_s1 && emit_free;
	assign load      = advance && (len_s1 >= MIN_REPORT_LEN);

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rpt.valid && rpt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (rpt.valid && rpt.ready) begin
			mods_s1 <= rpt.modifiers;
			keys_s1 <= {rpt.key_5, rpt.key_4, rpt.key_3, rpt.key_2, rpt.key_1, rpt.key_0};
			len_s1  <= rpt.report_length;
		end
	end

	bkre_diff u_diff (
		.clk    (clk),
		.arst_n (arst_n),
		.update (load),
		.mods   (mods_s1),
		.keys   (keys_s1),
		.ev_set (ev_set)
	);

	bkre_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.ev_set (ev_set),
		.free   (emit_free),
		.evt    (evt)
	);

endmodule

[design/bkre_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkre_check
// Port-level checks for the boot keyboard report decoder, bound to the top.
// ----------------------------------------------------------------------------
module bkre_check (
	input logic       clk,
	input logic       arst_n,
	input logic       rpt_ready,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic [7:0] evt_usage_code,
	input logic       evt_pressed,
	input logic [7:0] evt_modifier_info,
	input logic       evt_last
);

	// A stalled event word holds.
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt_usage_code) &&
		$stable(evt_pressed) && $stable(evt_modifier_info) && $stable(evt_last))
		else $error("event word changed while stalled");

	// No event is ever made for an empty or error slot code.
	a_code_real: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> evt_usage_code > 8'd3)
		else $error("event for a none or error code");

	// Input only stalls while events are being delivered.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rpt_ready |=> evt_valid)
		else $error("input stalled with no event pending");

endmodule

bind boot_keyboard_report_to_key_events bkre_check u_check (
	.clk               (clk),
	.arst_n            (arst_n),
	.rpt_ready         (rpt.ready),
	.evt_valid         (evt.valid),
	.evt_ready         (evt.ready),
	.evt_usage_code    (evt.usage_code),
	.evt_pressed       (evt.pressed),
	.evt_modifier_info (evt.modifier_info),
	.evt_last          (evt.last)
);

[tb/sv/tb_boot_keyboard_report_to_key_events.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boot_keyboard_report_to_key_events
// Drives boot keyboard reports into the decoder and checks every key event
// word against a predictor that keeps its own copy of the held keys and the
// modifier latch. A directed pass covers the corner cases, then random typing
// sequences run under bursty input and a stalling event sink.
// ----------------------------------------------------------------------------
module tb_boot_keyboard_report_to_key_events;

	import bkre_pkg::*;

	localparam int RANDOM_REPORTS = 190;
	localparam int HOLD_CYCLES    = 200;
	localparam int STALL_LIMIT    = 2000;
	localparam int TAIL_CYCLES    = 8;

	typedef struct packed {
		logic [7:0] modifiers;
		keys_t      keys;
		logic [6:0] report_length;
	} report_t;

	typedef struct packed {
		logic [7:0] usage_code;
		logic       pressed;
		logic [7:0] modifier_info;
		logic       last;
	} event_word_t;

	typedef enum int {SINK_STEADY, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

	// Predicts the key events of each accepted report and holds them until
	// they come out of the block.
	class key_event_tracker;
		keys_t       held_keys;
		logic [7:0]  mod_latch;
		event_word_t expected_q[$];
		int unsigned errors;

		function new();
			held_keys = '0;
			mod_latch = '0;
			errors    = 0;
		endfunction

		static function bit has_code(keys_t slots, logic [7:0] code);
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (slots[i] == code)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_report(report_t r);
			event_word_t ev[NUM_EVENTS];
			int          n;
			logic        now_on;
			logic [7:0]  old_code;
			logic [7:0]  cur_code;
			n = 0;
			// Short reports leave everything untouched.
			if (r.report_length < MIN_REPORT_LEN)
				return;
			// Tracked modifier bits first, each change as its own event.
			for (int i = 0; i < NUM_MODS; i++) begin
				now_on = |(r.modifiers & MOD_BITS[i]);
				if (now_on != |(mod_latch & MOD_BITS[i])) begin
					ev[n] = '{usage_code: MOD_CODES[i], pressed: now_on,
						modifier_info: MOD_BITS[i], last: 1'b0};
					n++;
					if (now_on)
						mod_latch = mod_latch | MOD_BITS[i];
					else
						mod_latch = mod_latch & ~MOD_BITS[i];
				end
			end
			// Then slot by slot: release of a vanished key, press of a new one.
			for (int s = 0; s < KEY_SLOTS; s++) begin
				old_code = held_keys[s];
				cur_code = r.keys[s];
				if (old_code > KEY_NONE_MAX && !has_code(r.keys, old_code)) begin
					ev[n] = '{usage_code: old_code, pressed: 1'b0,
						modifier_info: r.modifiers, last: 1'b0};
					n++;
				end
				if (cur_code > KEY_NONE_MAX && !has_code(held_keys, cur_code)) begin
					ev[n] = '{usage_code: cur_code, pressed: 1'b1,
						modifier_info: r.modifiers, last: 1'b0};
					n++;
				end
			end
			held_keys = r.keys;
			if (n > 0)
				ev[n-1].last = 1'b1;
			for (int k = 0; k < n; k++)
				expected_q.push_back(ev[k]);
		endfunction

		function void check_event(event_word_t got);
			event_word_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected event: code %02h pr %0b info %02h last %0b",
					$time, got.usage_code, got.pressed, got.modifier_info, got.last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.usage_code !== want.usage_code) begin
				$display("%0t: usage_code mismatch: expected %02h, actual %02h",
					$time, want.usage_code, got.usage_code);
				errors++;
			end
			if (got.pressed !== want.pressed) begin
				$display("%0t: pressed mismatch: expected %0b, actual %0b",
					$time, want.pressed, got.pressed);
				errors++;
			end
			if (got.modifier_info !== want.modifier_info) begin
				$display("%0t: modifier_info mismatch: expected %02h, actual %02h",
					$time, want.modifier_info, got.modifier_info);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last mismatch: expected %0b, actual %0b",
					$time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bkre_report_if rpt ();
	bkre_event_if  evt ();

	key_event_tracker tracker = new();
	bit               hold_sink = 1'b0;
	int unsigned      idle_cycles = 0;

	boot_keyboard_report_to_key_events u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rpt    (rpt),
		.evt    (evt)
	);

	// Clock: 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Builds a report with its key slots in slot order.
	function automatic report_t report_of(logic [7:0] m, logic [7:0] k0, logic [7:0] k1,
			logic [7:0] k2, logic [7:0] k3, logic [7:0] k4, logic [7:0] k5,
			logic [6:0] len);
		report_t r;
		r.modifiers     = m;
		r.keys[0]       = k0;
		r.keys[1]       = k1;
		r.keys[2]       = k2;
		r.keys[3]       = k3;
		r.keys[4]       = k4;
		r.keys[5]       = k5;
		r.report_length = len;
		return r;
	endfunction

	// Next report of a typing sequence: mostly small changes to the previous
	// report, with some fully random and some short reports mixed in.
	function automatic report_t typed_after(report_t prev);
		report_t     r;
		int unsigned pick;
		r    = prev;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			r.modifiers     = 8'($urandom);
			r.keys          = keys_t'({$urandom, $urandom});
			r.report_length = 7'($urandom_range(0, 64));
			return r;
		end
		if ($urandom_range(0, 2) == 0)
			r.modifiers = r.modifiers ^ 8'(1 << $urandom_range(0, 7));
		if ($urandom_range(0, 9) == 0)
			r.modifiers = 8'($urandom);
		for (int s = 0; s < KEY_SLOTS; s++) begin
			case ($urandom_range(0, 9))
				5, 6: begin
					r.keys[s] = 8'(8'h04 + $urandom_range(0, 11));
				end
				7: begin
					r.keys[s] = 8'($urandom_range(0, 3));
				end
				8: begin
					r.keys[s] = 8'h00;
				end
				9: begin
					r.keys[s] = 8'($urandom_range(0, 255));
				end
				default: begin
				end
			endcase
		end
		if (pick < 22)
			r.report_length = 7'($urandom_range(0, 7));
		else if (pick < 75)
			r.report_length = 7'd8;
		else
			r.report_length = 7'($urandom_range(9, 64));
		return r;
	endfunction

	// Offers one report and returns at the edge where it is taken. The valid
	// stays high so that a following report can go out back to back.
	task automatic send_report(report_t r);
		rpt.valid         <= 1'b1;
		rpt.modifiers     <= r.modifiers;
		rpt.key_0         <= r.keys[0];
		rpt.key_1         <= r.keys[1];
		rpt.key_2         <= r.keys[2];
		rpt.key_3         <= r.keys[3];
		rpt.key_4         <= r.keys[4];
		rpt.key_5         <= r.keys[5];
		rpt.report_length <= r.report_length;
		do
			@(posedge clk);
		while (!rpt.ready);
		tracker.note_report(r);
	endtask

	// Stops offering and waits until every predicted event has come out.
	task automatic pause_until_drained();
		rpt.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	// Report source: directed corner cases, then random typing in bursts.
	initial begin : report_source
		report_t prev;
		report_t r;
		int      sent;
		int      burst;
		int      gap;
		bit      hold_done;
		bit      pause_done;
		sent       = 0;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		rpt.valid         <= 1'b0;
		rpt.modifiers     <= '0;
		rpt.key_0         <= '0;
		rpt.key_1         <= '0;
		rpt.key_2         <= '0;
		rpt.key_3         <= '0;
		rpt.key_4         <= '0;
		rpt.key_5         <= '0;
		rpt.report_length <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing changes from the reset state.
		send_report(report_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		// Every modifier and six keys go down, then the same report again.
		send_report(report_of(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 7'd8));
		send_report(report_of(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 7'd8));
		// Keys moving between slots are not changes.
		send_report(report_of(8'hFF, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 7'd8));
		// Everything released.
		send_report(report_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		// GUI bits alone give no event.
		send_report(report_of(8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		// Highest codes at a length of 64.
		send_report(report_of(8'h77, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA, 7'd64));
		// All six modifiers flip and all six keys are replaced: the most events.
		send_report(report_of(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 7'd8));
		// Error codes in the slots are neither pressed nor released.
		send_report(report_of(8'h01, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00, 7'd8));
		// Short reports are ignored.
		send_report(report_of(8'h01, 8'h10, 8'h10, 8'h11, 8'h11, 8'h00, 8'h00, 7'd7));
		send_report(report_of(8'h01, 8'h10, 8'h10, 8'h11, 8'h11, 8'h00, 8'h00, 7'd0));
		// A new code in two slots gives two presses, and two releases later.
		send_report(report_of(8'h01, 8'h10, 8'h10, 8'h11, 8'h11, 8'h00, 8'h00, 7'd8));
		send_report(report_of(8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		// Walk a single modifier bit across the byte, GUI bits included.
		send_report(report_of(8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(report_of(8'h04, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(report_of(8'h08, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(report_of(8'h10, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(report_of(8'h20, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(report_of(8'h40, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(report_of(8'h80, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		prev = report_of(8'hFF, 8'h04, 8'hFF, 8'h80, 8'h7F, 8'h10, 8'h00, 7'd63);
		send_report(prev);
		pause_until_drained();

		// Random typing sequences in bursts.
		while (sent < RANDOM_REPORTS) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				prev = typed_after(prev);
				send_report(prev);
				sent++;
			end
			if (!hold_done && sent >= 60) begin
				// The sink holds off while full reports keep coming.
				hold_done = 1'b1;
				hold_sink = 1'b1;
				for (int b = 0; b < 16; b++) begin
					r = typed_after(prev);
					if (b % 2 == 0)
						r.keys = {8'h25, 8'h24, 8'h23, 8'h22, 8'h21, 8'h20};
					else
						r.keys = {8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30};
					r.report_length = 7'd8;
					prev = r;
					send_report(prev);
					sent++;
				end
			end
			if (!pause_done && sent >= 130) begin
				pause_done = 1'b1;
				pause_until_drained();
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				if (gap > 0) begin
					rpt.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("boot_keyboard_report_to_key_events verification clean");
		else
			$display("boot_keyboard_report_to_key_events verification failed");
		$finish;
	end

	// Event sink: changes between steady, random and periodic stalling, and
	// holds off for a long stretch once when asked.
	initial begin : event_sink
		sink_mode_t  mode;
		int unsigned mode_left;
		int unsigned tick;
		mode      = SINK_STEADY;
		mode_left = 0;
		tick      = 0;
		evt.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_sink) begin
				evt.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_sink = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = sink_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				tick++;
				case (mode)
					SINK_STEADY: begin
						evt.ready <= 1'b1;
					end
					SINK_RANDOM: begin
						evt.ready <= ($urandom_range(0, 99) >= 35);
					end
					default: begin
						evt.ready <= ((tick % 7) < 4);
					end
				endcase
				@(posedge clk);
			end
		end
	end

	// Event monitor: every accepted word is checked in order.
	always @(posedge clk) begin : event_monitor
		event_word_t seen;
		if (arst_n && evt.valid && evt.ready) begin
			seen.usage_code    = evt.usage_code;
			seen.pressed       = evt.pressed;
			seen.modifier_info = evt.modifier_info;
			seen.last          = evt.last;
			tracker.check_event(seen);
		end
	end

	// Watchdog: ends the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rpt.valid && rpt.ready) || (evt.valid && evt.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("boot_keyboard_report_to_key_events verification failed");
					$finish;
				end
			end
		end
	end

endmodule

[boot_keyboard_report_to_key_events.f]
design/bkre_pkg.sv
design/bkre_report_if.sv
design/bkre_event_if.sv
design/bkre_diff.sv
design/bkre_emit.sv
design/boot_keyboard_report_to_key_events.sv
design/bkre_check.sv
tb/sv/tb_boot_keyboard_report_to_key_events.sv
